// File: hw/rtl/btme_pkg.sv
// shared types, constants and helpers for the bcd time to elapsed ms block
package btme_pkg;

  localparam int unsigned PRESCALE_BITS_DEF = 15;

  localparam int unsigned TIME_W     = 22;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned STAMP_W    = 27;
  localparam int unsigned MS_W       = 28;
  localparam int unsigned SECS_W     = 18;
  localparam int unsigned QUOT_W     = 10;
  localparam int unsigned CFG_DATA_W = 15;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned PRESCALE_RESET = 255;
  localparam int unsigned MS_PER_SEC     = 1000;
  localparam int unsigned SECS_PER_MIN   = 60;
  localparam int unsigned SECS_PER_HOUR  = 3600;
  localparam int unsigned DAY_MS         = 86400000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESCALE = 2'd0,
    CFG_READY    = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [TIME_W-1:0]  time_word;
    logic [COUNT_W-1:0] subsec_count;
    logic [STAMP_W-1:0] since_stamp;
  } in_t;

  typedef struct packed {
    logic [MS_W-1:0] now_ms;
    logic [MS_W-1:0] elapsed_ms;
  } out_t;

  // fields that ride along the divider chain
  typedef struct packed {
    logic               valid;
    logic [SECS_W-1:0]  secs;
    logic [STAMP_W-1:0] since;
  } side_t;

  // two bcd digits, tens in the upper bits, no range check
  function automatic logic [6:0] bcd_decode(input logic [6:0] digits);
    logic [6:0] tens;
    logic [6:0] units;
    tens  = 7'(digits[6:4]);
    units = 7'(digits[3:0]);
    return 7'(tens * 7'd10) + units;
  endfunction

endpackage

// File: hw/rtl/btme_front.sv
// input stage: bcd decode to seconds and subsecond numerator
module btme_front #(
  parameter int unsigned PRESCALE_BITS = btme_pkg::PRESCALE_BITS_DEF,
  localparam int unsigned NUM_W = PRESCALE_BITS + btme_pkg::QUOT_W
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  btme_pkg::in_t            in_i,
  input  logic [PRESCALE_BITS-1:0] prescale_i,
  output btme_pkg::side_t          side_o,
  output logic [NUM_W-1:0]         rem_o
);

  logic [6:0]                       hrs, mins, secs;
  logic [btme_pkg::SECS_W-1:0]      secs_d, secs_q;
  logic [btme_pkg::COUNT_W-1:0]     pre_ext, diff;
  logic                             in_range;
  logic [NUM_W-1:0]                 num_d, num_q;
  logic [btme_pkg::STAMP_W-1:0]     since_q;
  logic                             valid_q;

  always_comb begin
    hrs  = btme_pkg::bcd_decode({1'b0, in_i.time_word[21:16]});
    mins = btme_pkg::bcd_decode(in_i.time_word[14:8]);
    secs = btme_pkg::bcd_decode(in_i.time_word[6:0]);
    secs_d = btme_pkg::SECS_W'(btme_pkg::SECS_W'(hrs) *
                               btme_pkg::SECS_W'(btme_pkg::SECS_PER_HOUR))
           + btme_pkg::SECS_W'(btme_pkg::SECS_W'(mins) *
                               btme_pkg::SECS_W'(btme_pkg::SECS_PER_MIN))
           + btme_pkg::SECS_W'(secs);

    // count above prescale gives no fraction
    pre_ext  = btme_pkg::COUNT_W'(prescale_i);
    in_range = (in_i.subsec_count <= pre_ext);
    diff     = pre_ext - in_i.subsec_count;
    num_d    = in_range ? NUM_W'(NUM_W'(diff) * NUM_W'(btme_pkg::MS_PER_SEC)) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    secs_q  <= secs_d;
    num_q   <= num_d;
    since_q <= in_i.since_stamp;
  end

  assign side_o = '{valid: valid_q, secs: secs_q, since: since_q};
  assign rem_o  = num_q;

endmodule

// File: hw/rtl/btme_div_cell.sv
// one restoring division step, registered, yields one quotient bit
module btme_div_cell #(
  parameter int unsigned PRESCALE_BITS = btme_pkg::PRESCALE_BITS_DEF,
  localparam int unsigned NUM_W = PRESCALE_BITS + btme_pkg::QUOT_W,
  localparam int unsigned DIV_W = PRESCALE_BITS + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [DIV_W-1:0]            divisor_i,
  input  btme_pkg::side_t             side_i,
  input  logic [NUM_W-1:0]            rem_i,
  input  logic [btme_pkg::QUOT_W-1:0] quot_i,
  output btme_pkg::side_t             side_o,
  output logic [NUM_W-1:0]            rem_o,
  output logic [btme_pkg::QUOT_W-1:0] quot_o
);

  logic [NUM_W-1:0]            cmp, rest, rem_d, rem_q;
  logic                        ge;
  logic [btme_pkg::QUOT_W-1:0] quot_d, quot_q;
  logic                        valid_q;
  logic [btme_pkg::SECS_W-1:0] secs_q;
  logic [btme_pkg::STAMP_W-1:0] since_q;

  // divisor sits at the top quotient position, remainder moves up each cell
  always_comb begin
    cmp    = NUM_W'(divisor_i) << (btme_pkg::QUOT_W - 1);
    ge     = (rem_i >= cmp);
    rest   = ge ? (rem_i - cmp) : rem_i;
    rem_d  = rest << 1;
    quot_d = {quot_i[btme_pkg::QUOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quot_q  <= quot_d;
    secs_q  <= side_i.secs;
    since_q <= side_i.since;
  end

  assign side_o = '{valid: valid_q, secs: secs_q, since: since_q};
  assign rem_o  = rem_q;
  assign quot_o = quot_q;

endmodule

// File: hw/rtl/btme_tail.sv
// back end: ms assembly, elapsed with midnight wrap, output register
module btme_tail (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  btme_pkg::side_t             side_i,
  input  logic [btme_pkg::QUOT_W-1:0] quot_i,
  input  logic                        ready_i,
  output logic                        done_o,
  output btme_pkg::out_t              result_o
);

  logic [btme_pkg::MS_W-1:0]    now_d, now_q;
  logic [btme_pkg::STAMP_W-1:0] since_q;
  logic                         valid_a_q;
  logic [btme_pkg::MS_W-1:0]    since_ext, elapsed;
  btme_pkg::out_t               res_d, res_q;
  logic                         done_q;

  assign now_d = btme_pkg::MS_W'(btme_pkg::MS_W'(side_i.secs) *
                                 btme_pkg::MS_W'(btme_pkg::MS_PER_SEC))
               + btme_pkg::MS_W'(quot_i);

  always_comb begin
    since_ext = btme_pkg::MS_W'(since_q);
    if (now_q >= since_ext) begin
      elapsed = now_q - since_ext;
    end else begin
      elapsed = btme_pkg::MS_W'(btme_pkg::DAY_MS) - since_ext + now_q;
    end
    if (ready_i) begin
      res_d = '{now_ms: now_q, elapsed_ms: elapsed};
    end else begin
      res_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      valid_a_q <= side_i.valid;
      done_q    <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q   <= now_d;
    since_q <= side_i.since;
    res_q   <= res_d;
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

// File: hw/rtl/bcd_time_to_ms_elapsed.sv
// top level: bcd time snapshot to time of day and elapsed milliseconds
//
// one transaction is accepted on every cycle that start_i is high; busy_o
// stays low, so items may follow each other back to back. each result shows
// on result_o for one cycle with done_o high, after passing through one
// input stage (bcd decode, subsecond numerator), a row of 10 division cells
// that each settle one quotient bit of the subsecond fraction, then one stage
// that scales seconds to ms and adds the fraction and one that forms the
// elapsed time and drives the output register. the receiver cannot stall and
// nothing is buffered, so a result must be taken in the cycle it appears.
// the configuration channel is always ready; write it only while no
// transaction is in flight, since the prescale and ready bits are read live
// by the pipeline. with clock_ready low both result fields come out zero.
module bcd_time_to_ms_elapsed #(
  parameter int unsigned PRESCALE_BITS = btme_pkg::PRESCALE_BITS_DEF,
  localparam int unsigned NUM_W = PRESCALE_BITS + btme_pkg::QUOT_W,
  localparam int unsigned DIV_W = PRESCALE_BITS + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // item channel
  input  logic                            start_i,
  output logic                            busy_o,
  input  btme_pkg::in_t                   in_i,
  output logic                            done_o,
  output btme_pkg::out_t                  result_o,
  // configuration channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [btme_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [btme_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NCELL = btme_pkg::QUOT_W;

  // configuration registers
  logic [PRESCALE_BITS-1:0]     prescale_d, prescale_q;
  logic                         ready_d, ready_q;
  logic [btme_pkg::COUNT_W-1:0] cfg_wide;
  logic                         cfg_we;

  // divider chain wiring, element 0 is the input stage
  btme_pkg::side_t             side   [NCELL+1];
  logic [NUM_W-1:0]            rem    [NCELL+1];
  logic [btme_pkg::QUOT_W-1:0] quot   [NCELL+1];
  logic [DIV_W-1:0]            divisor;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  // prescale keeps only its low PRESCALE_BITS bits
  always_comb begin
    cfg_wide   = btme_pkg::COUNT_W'(cfg_data_i);
    prescale_d = prescale_q;
    ready_d    = ready_q;
    if (cfg_we) begin
      if (cfg_index_i == btme_pkg::CFG_PRESCALE) begin
        prescale_d = cfg_wide[PRESCALE_BITS-1:0];
      end else if (cfg_index_i == btme_pkg::CFG_READY) begin
        ready_d = cfg_data_i[0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= PRESCALE_BITS'(btme_pkg::PRESCALE_RESET);
      ready_q    <= 1'b0;
    end else begin
      prescale_q <= prescale_d;
      ready_q    <= ready_d;
    end
  end

  // fraction divides by prescale plus one
  assign divisor = DIV_W'(prescale_q) + DIV_W'(1);

  btme_front #(
    .PRESCALE_BITS (PRESCALE_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .in_i       (in_i),
    .prescale_i (prescale_q),
    .side_o     (side[0]),
    .rem_o      (rem[0])
  );

  // quotient starts empty, each cell shifts in one bit, msb first
  assign quot[0] = '0;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    btme_div_cell #(
      .PRESCALE_BITS (PRESCALE_BITS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (divisor),
      .side_i    (side[i]),
      .rem_i     (rem[i]),
      .quot_i    (quot[i]),
      .side_o    (side[i+1]),
      .rem_o     (rem[i+1]),
      .quot_o    (quot[i+1])
    );
  end

  btme_tail u_tail (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .side_i   (side[NCELL]),
    .quot_i   (quot[NCELL]),
    .ready_i  (ready_q),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

// File: bench/btme_checker.sv
// checker for the bcd time to elapsed ms block: predicts each result and compares it
module btme_checker
  import btme_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  in_t                   in_i,
  input  logic                  done_i,
  input  out_t                  result_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_cnt_o,
  output int                    waiting_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow copy of the two registers
  logic [CFG_DATA_W-1:0] prescale_q;
  logic                  clk_ready_q;

  out_t ms_expected_q[$];
  out_t want_r;

  function automatic logic [31:0] bcd_pair(input logic [3:0] tens, input logic [3:0] units);
    return 32'(tens) * 32'd10 + 32'(units);
  endfunction

  // time of day and elapsed ms for one snapshot
  function automatic out_t ms_of_snapshot(input in_t snap, input logic [CFG_DATA_W-1:0] presc,
                                          input logic rdy);
    logic [31:0] hrs;
    logic [31:0] mins;
    logic [31:0] secs;
    logic [31:0] frac;
    logic [31:0] now;
    logic [31:0] since;
    logic [31:0] elapsed;
    out_t        res;
    res = '0;
    if (rdy) begin
      hrs  = bcd_pair({2'b00, snap.time_word[21:20]}, snap.time_word[19:16]);
      mins = bcd_pair({1'b0, snap.time_word[14:12]}, snap.time_word[11:8]);
      secs = bcd_pair({1'b0, snap.time_word[6:4]}, snap.time_word[3:0]);
      frac = '0;
      if (32'(snap.subsec_count) <= 32'(presc)) begin
        frac = ((32'(presc) - 32'(snap.subsec_count)) * 32'(MS_PER_SEC)) / (32'(presc) + 32'd1);
      end
      now = (((hrs * 32'(SECS_PER_MIN)) + mins) * 32'(SECS_PER_MIN) + secs)
            * 32'(MS_PER_SEC) + frac;
      since = 32'(snap.since_stamp);
      // past midnight the stamp is ahead of now, so one day is added back
      if (now >= since) elapsed = now - since;
      else elapsed = (32'(DAY_MS) - since) + now;
      res.now_ms     = now[MS_W-1:0];
      res.elapsed_ms = elapsed[MS_W-1:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q     = CFG_DATA_W'(PRESCALE_RESET);
      clk_ready_q    = 1'b0;
      ms_expected_q.delete();
      mismatch_cnt_o = 0;
      waiting_cnt_o  = 0;
    end else begin
      if (start_i && !busy_i) begin
        ms_expected_q.push_back(ms_of_snapshot(in_i, prescale_q, clk_ready_q));
      end
      if (done_i) begin
        if (ms_expected_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t unexpected result now_ms=%0d elapsed_ms=%0d", $time,
                   result_i.now_ms, result_i.elapsed_ms);
        end else begin
          want_r = ms_expected_q.pop_front();
          if (result_i.now_ms !== want_r.now_ms) begin
            mismatch_cnt_o++;
            $display("%0t now_ms expected %0d actual %0d", $time, want_r.now_ms,
                     result_i.now_ms);
          end
          if (result_i.elapsed_ms !== want_r.elapsed_ms) begin
            mismatch_cnt_o++;
            $display("%0t elapsed_ms expected %0d actual %0d", $time, want_r.elapsed_ms,
                     result_i.elapsed_ms);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PRESCALE: prescale_q = cfg_data_i;
          CFG_READY:    clk_ready_q = cfg_data_i[0];
          default:      ;
        endcase
      end
      waiting_cnt_o = ms_expected_q.size();
    end
  end

endmodule

// File: bench/tb.sv
// testbench top for the bcd time to elapsed ms block: stimulus, watchdog and verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import btme_pkg::*;

  // pipeline depth, used with a margin when draining before register writes
  localparam int unsigned LATENCY   = 13;
  localparam int unsigned WDOG_MAX  = 4000;
  localparam int unsigned PHASES    = 8;
  localparam int unsigned PHASE_LEN = 240;
  // indexes with no register behind them, writes to them must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start_i = 1'b0;
  logic                  busy_o;
  in_t                   in_i = '0;
  logic                  done_o;
  out_t                  result_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int          mismatch_cnt;
  int          waiting_cnt;
  int unsigned quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  bcd_time_to_ms_elapsed uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .in_i        (in_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  btme_checker chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .in_i           (in_i),
    .done_i         (done_o),
    .result_i       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatch_cnt_o (mismatch_cnt),
    .waiting_cnt_o  (waiting_cnt)
  );

  // watchdog: any handshake on either channel or a result counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // two bcd digits of a value 0..99, tens in the upper nibble
  function automatic logic [7:0] to_bcd(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // well-formed time word, the two unused bits left at zero
  function automatic logic [TIME_W-1:0] bcd_time(input int unsigned h, input int unsigned m,
                                                 input int unsigned s);
    logic [7:0] hh;
    logic [7:0] mm;
    logic [7:0] ss;
    hh = to_bcd(h);
    mm = to_bcd(m);
    ss = to_bcd(s);
    return {hh[5:0], 1'b0, mm[6:0], 1'b0, ss[6:0]};
  endfunction

  function automatic in_t snap(input logic [TIME_W-1:0] tw, input int unsigned cnt,
                               input int unsigned since);
    in_t r;
    r.time_word    = tw;
    r.subsec_count = COUNT_W'(cnt);
    r.since_stamp  = STAMP_W'(since);
    return r;
  endfunction

  // mostly real clock readings, the rest raw noise and corner values
  function automatic in_t make_snapshot(input logic [CFG_DATA_W-1:0] presc);
    in_t         r;
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 80) r.time_word = bcd_time($urandom_range(23), $urandom_range(59),
                                         $urandom_range(59));
    else r.time_word = TIME_W'($urandom);
    sel = $urandom_range(99);
    if (sel < 65) begin
      r.subsec_count = COUNT_W'($urandom_range(int'(presc)));
    end else if (sel < 80) begin
      r.subsec_count = COUNT_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       r.subsec_count = '0;
        1:       r.subsec_count = COUNT_W'(presc);
        2:       r.subsec_count = COUNT_W'(int'(presc) + 1);
        default: r.subsec_count = '1;
      endcase
    end
    sel = $urandom_range(99);
    if (sel < 70) begin
      r.since_stamp = STAMP_W'($urandom_range(DAY_MS - 1));
    end else if (sel < 85) begin
      r.since_stamp = STAMP_W'($urandom);
    end else begin
      case ($urandom_range(3))
        0:       r.since_stamp = '0;
        1:       r.since_stamp = STAMP_W'(DAY_MS - 1);
        2:       r.since_stamp = STAMP_W'(DAY_MS);
        default: r.since_stamp = '1;
      endcase
    end
    return r;
  endfunction

  // hold start high until the block takes the transaction, return at a falling edge
  task automatic drive_item(input in_t item);
    start_i <= 1'b1;
    in_i    <= item;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // random idle cycles between transactions, junk on the data lines meanwhile
  task automatic sender_gap(input int unsigned pct);
    in_t junk;
    while ($urandom_range(99) < pct) begin
      junk.time_word    = TIME_W'($urandom);
      junk.subsec_count = COUNT_W'($urandom);
      junk.since_stamp  = STAMP_W'($urandom);
      start_i <= 1'b0;
      in_i    <= junk;
      @(negedge clk_i);
    end
  endtask

  // stop sending, wait until every result is back and the pipe has run dry
  task automatic settle();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (waiting_cnt != 0) @(negedge clk_i);
    repeat (LATENCY + 3) @(negedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    int unsigned           pct_tab [3];
    logic [CFG_DATA_W-1:0] presc;
    logic                  rdy;
    pct_tab = '{0, 84, 11};

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // clock not ready out of reset: results must be zero whatever comes in
    drive_item(snap('1, 16'hFFFF, 32'h07FF_FFFF));
    drive_item(snap(bcd_time(23, 59, 59), 0, 1));
    settle();

    // unused indexes first, then ready; prescale stays at its reset value
    write_cfg(CFG_SPARE_LO, CFG_DATA_W'($urandom));
    write_cfg(CFG_SPARE_HI, '1);
    write_cfg(CFG_READY, {14'($urandom), 1'b1});

    drive_item(snap('0, PRESCALE_RESET, 0));              // midnight, no fraction
    drive_item(snap('0, 0, 0));                           // largest fraction
    drive_item(snap(bcd_time(23, 59, 59), 0, DAY_MS - 1));
    drive_item(snap(bcd_time(23, 59, 59), PRESCALE_RESET + 1, 0));  // count above prescale
    drive_item(snap('1, 16'hFFFF, 32'h07FF_FFFF));        // stamp beyond a day
    drive_item(snap('1, 0, 0));                           // largest now from bad digits
    drive_item(snap(bcd_time(12, 0, 0), 128, 43200500));  // crossed midnight
    drive_item(snap('0, PRESCALE_RESET, 1));
    drive_item(snap({6'h0F, 1'b1, 7'h5A, 1'b1, 7'h3C}, 17, 5));  // non-decimal digits
    drive_item(snap(bcd_time(1, 2, 3), PRESCALE_RESET, 3723000)); // stamp equals now
    drive_item(snap(bcd_time(0, 0, 1), 100, DAY_MS));
    settle();

    // smallest prescale: only count zero gives a (zero) fraction
    write_cfg(CFG_PRESCALE, '0);
    drive_item(snap(bcd_time(9, 30, 0), 0, 100));
    drive_item(snap(bcd_time(9, 30, 0), 1, 100));
    settle();

    // largest prescale
    write_cfg(CFG_PRESCALE, '1);
    drive_item(snap(bcd_time(18, 45, 30), 0, 0));
    drive_item(snap(bcd_time(18, 45, 30), 32767, 0));
    drive_item(snap(bcd_time(18, 45, 30), 32768, 0));
    drive_item(snap(bcd_time(18, 45, 30), 65535, 80000000));

    // random phases, each with its own register setting and idle pattern
    for (int unsigned p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0:       presc = CFG_DATA_W'(PRESCALE_RESET);
        1:       presc = '0;
        2:       presc = '1;
        3:       presc = CFG_DATA_W'(1);
        5:       presc = CFG_DATA_W'(999);
        default: presc = CFG_DATA_W'($urandom);
      endcase
      rdy = (p != 4) && (p != 7);
      write_cfg(CFG_PRESCALE, presc);
      write_cfg(CFG_READY, {14'($urandom), rdy});
      for (int unsigned i = 0; i < PHASE_LEN; i++) begin
        drive_item(make_snapshot(presc));
        // hold off mid-phase until the pipe is empty
        if (p == 1 && i == PHASE_LEN / 2) settle();
        sender_gap(pct_tab[p % 3]);
      end
    end

    settle();
    if (mismatch_cnt == 0 && waiting_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
